// ----- rtl/tci_pkg.sv -----
// ----------------------------------------------------------------------------
// tci_pkg
// Types, register codes and helper functions shared by the tide interpolator.
// ----------------------------------------------------------------------------
package tci_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int WW     = 17;

  localparam logic [2:0] REG_INTERVAL    = 3'd0;
  localparam logic [2:0] REG_HIGH_OFFSET = 3'd1;
  localparam logic [2:0] REG_LOW_OFFSET  = 3'd2;
  localparam logic [2:0] REG_HIGH_GAIN   = 3'd3;
  localparam logic [2:0] REG_LOW_GAIN    = 3'd4;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef struct packed {
    logic [31:0]        event_minute;
    logic signed [15:0] event_level;
    logic               is_high;
    logic               new_series;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        sample_minute;
    logic signed [15:0] sample_level;
    logic               last_sample;
    logic               truncated;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  interval_minutes;
    logic [10:0] high_offset_minutes;
    logic [10:0] low_offset_minutes;
    logic [15:0] high_gain;
    logic [15:0] low_gain;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic corr;
    logic mod_step;
    logic modiv_step;
    logic setup;
    logic mul_e;
    logic div_init;
    logic div_step;
    logic look;
    logic mul_w;
    logic out_load;
    logic advance;
    logic store;
  } dp_cmd_t;

  typedef struct packed {
    logic go;
    logic mod_done;
    logic modiv_done;
    logic gap_ok;
    logic div_done;
    logic last;
  } dp_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] res;
    if (v > 40'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -40'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // Cosine in Q30 of an angle in [0, pi/2], Taylor series through a^12.
  function automatic logic [63:0] cos_q30(input logic [63:0] a);
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] p;
    logic [63:0] t;
    a2 = (a * a) >> 30;
    term = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      p = (a2 * term) >> 30;
      unique case (k)
        0:       t = p / 64'd132;
        1:       t = p / 64'd90;
        2:       t = p / 64'd56;
        3:       t = p / 64'd30;
        4:       t = p / 64'd12;
        default: t = p >> 1;
      endcase
      if (t > Q30_ONE) begin
        t = Q30_ONE;
      end
      term = Q30_ONE - t;
    end
    return term;
  endfunction

endpackage

// ----- rtl/tide_cosine_interpolator.sv -----
// ----------------------------------------------------------------------------
// tide_cosine_interpolator
// Resamples a stream of tide extremes onto a clock-aligned minute grid.
// ----------------------------------------------------------------------------
// Each accepted extreme is corrected by offset and gain, then the gap from the
// stored extreme is filled with up to MAX_SAMPLES cosine-blended samples. An
// extreme that opens a gap goes through correction and grid alignment, a
// reciprocal reduction of the previous minute modulo 60 and a remainder by the
// interval, then each emitted sample passes the restoring divider that forms
// the table index. One extreme is processed at a time; the input is ready only
// while the block is idle.
module tide_cosine_interpolator #(
  parameter int MAX_SAMPLES     = 64,
  parameter int COS_TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tci_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tci_pkg::out_item_t              out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tci_pkg::ADDR_W-1:0]      paddr,
  input  logic [tci_pkg::DATA_W-1:0]      pwdata,
  output logic [tci_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import tci_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_minutes    <= 6'd10;
      cfg.high_offset_minutes <= '0;
      cfg.low_offset_minutes  <= '0;
      cfg.high_gain           <= '0;
      cfg.low_gain            <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_INTERVAL:    cfg.interval_minutes    <= pwdata[5:0];
        REG_HIGH_OFFSET: cfg.high_offset_minutes <= pwdata[10:0];
        REG_LOW_OFFSET:  cfg.low_offset_minutes  <= pwdata[10:0];
        REG_HIGH_GAIN:   cfg.high_gain           <= pwdata[15:0];
        REG_LOW_GAIN:    cfg.low_gain            <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_INTERVAL:    prdata = DATA_W'(cfg.interval_minutes);
      REG_HIGH_OFFSET: prdata = DATA_W'(cfg.high_offset_minutes);
      REG_LOW_OFFSET:  prdata = DATA_W'(cfg.low_offset_minutes);
      REG_HIGH_GAIN:   prdata = DATA_W'(cfg.high_gain);
      REG_LOW_GAIN:    prdata = DATA_W'(cfg.low_gain);
      default:         prdata = '0;
    endcase
  end

  tci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tci_datapath #(
    .MAX_SAMPLES     (MAX_SAMPLES),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

// ----- rtl/tci_ctrl.sv -----
// ----------------------------------------------------------------------------
// tci_ctrl
// Sequencer that steps the datapath through correction, grid setup and samples.
// ----------------------------------------------------------------------------
module tci_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tci_pkg::dp_status_t status,
  output tci_pkg::dp_cmd_t    cmd
);
  import tci_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CORR  = 13'b0000000000010,
    S_MOD60 = 13'b0000000000100,
    S_MODIV = 13'b0000000001000,
    S_SETUP = 13'b0000000010000,
    S_MULE  = 13'b0000000100000,
    S_DIVI  = 13'b0000001000000,
    S_DIV   = 13'b0000010000000,
    S_LOOK  = 13'b0000100000000,
    S_MULW  = 13'b0001000000000,
    S_OUTL  = 13'b0010000000000,
    S_WAIT  = 13'b0100000000000,
    S_STORE = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_WAIT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_CORR;
        end
      end
      S_CORR: begin
        cmd.corr = 1'b1;
        state_next = status.go ? S_MOD60 : S_STORE;
      end
      S_MOD60: begin
        cmd.mod_step = 1'b1;
        if (status.mod_done) begin
          state_next = S_MODIV;
        end
      end
      S_MODIV: begin
        cmd.modiv_step = 1'b1;
        if (status.modiv_done) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_next = status.gap_ok ? S_MULE : S_STORE;
      end
      S_MULE: begin
        cmd.mul_e = 1'b1;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        state_next = S_MULW;
      end
      S_MULW: begin
        cmd.mul_w = 1'b1;
        state_next = S_OUTL;
      end
      S_OUTL: begin
        cmd.out_load = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) begin
          cmd.advance = !status.last;
          state_next = status.last ? S_STORE : S_MULE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tci_datapath.sv -----
// ----------------------------------------------------------------------------
// tci_datapath
// Correction, grid alignment, restoring divider, weight table and blending.
// ----------------------------------------------------------------------------
module tci_datapath #(
  parameter int MAX_SAMPLES     = 64,
  parameter int COS_TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  tci_pkg::cfg_t       cfg,
  input  tci_pkg::in_item_t   in_item,
  input  tci_pkg::dp_cmd_t    cmd,
  output tci_pkg::dp_status_t status,
  output tci_pkg::out_item_t  out_item
);
  import tci_pkg::*;

  localparam int LD  = $clog2(COS_TABLE_DEPTH);
  localparam int QW  = LD + 1;
  localparam int EDW = 33 + LD;
  localparam int NW  = 34 + LD;
  localparam int IW  = $clog2(COS_TABLE_DEPTH + 1);
  localparam int KW  = $clog2(MAX_SAMPLES) + 1;

  // Reciprocal of 60 scaled by 2^37, exact for every 32-bit minute.
  localparam logic [31:0] RECIP60 = 32'h8888_8889;

  typedef logic [WW-1:0] wtab_t [COS_TABLE_DEPTH + 1];

  // Entry i holds (1 - cos(pi*i/D)) / 2 in Q16.
  function automatic wtab_t build_wtab();
    wtab_t       tab;
    logic [63:0] c;
    logic [63:0] v;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      if (2 * i <= COS_TABLE_DEPTH) begin
        c = cos_q30(PI_Q30 * 64'(i) / COS_TABLE_DEPTH);
        v = Q30_ONE - c;
      end else begin
        c = cos_q30(PI_Q30 * 64'(COS_TABLE_DEPTH - i) / COS_TABLE_DEPTH);
        v = Q30_ONE + c;
      end
      tab[i] = WW'((v + 64'd16384) >> 15);
    end
    return tab;
  endfunction

  localparam wtab_t WTAB = build_wtab();

  logic               have_prev;
  logic [31:0]        prev_min;
  logic signed [15:0] prev_lvl;
  logic [31:0]        cur_min;
  logic signed [15:0] cur_lvl;
  logic signed [32:0] prod_lg;
  logic               fresh;
  logic [31:0]        dur;
  logic [31:0]        msh;
  logic [63:0]        prod60;
  logic [5:0]         rm;
  logic [4:0]         cnt;
  logic [32:0]        e;
  logic [KW-1:0]      k;
  logic               trunc;
  logic [EDW-1:0]     ed;
  logic [NW-1:0]      num;
  logic [NW-1:0]      dv;
  logic [QW-1:0]      q;
  logic [WW-1:0]      w;
  logic signed [34:0] pw;

  logic [5:0]         iv;
  logic [10:0]        off;
  logic [15:0]        gain;
  logic [26:0]        q60;
  logic [31:0]        m60;
  logic [5:0]         rem60_next;
  logic [6:0]         tiv;
  logic [5:0]         rm_next;
  logic [5:0]         r_val;
  logic [32:0]        span;
  logic signed [32:0] lvl_round;
  logic               ge;
  logic [QW-1:0]      qcap;
  logic signed [16:0] change;
  logic signed [34:0] pw_round;
  logic [32:0]        e_next;

  assign iv   = (cfg.interval_minutes == 6'd0) ? 6'd1 : cfg.interval_minutes;
  assign off  = in_item.is_high ? cfg.high_offset_minutes : cfg.low_offset_minutes;
  assign gain = in_item.is_high ? cfg.high_gain : cfg.low_gain;

  assign q60        = prod60[63:37];
  assign m60        = prev_min - (32'({q60, 6'd0}) - 32'({q60, 2'd0}));
  assign rem60_next = m60[5:0];
  assign tiv        = {rm, msh[31]};
  assign rm_next    = (tiv >= {1'b0, iv}) ? 6'(tiv - {1'b0, iv}) : tiv[5:0];
  assign r_val      = (rm == 6'd0) ? 6'd0 : 6'(iv - rm);
  assign span       = 33'(r_val) + 33'(MAX_SAMPLES) * 33'(iv);

  assign lvl_round = (prod_lg + 33'sd8192) >>> 14;
  assign ge        = (num >= dv);
  assign qcap      = (q > QW'(COS_TABLE_DEPTH)) ? QW'(COS_TABLE_DEPTH) : q;
  assign change    = 17'(cur_lvl) - 17'(prev_lvl);
  assign pw_round  = (pw + 35'sd32768) >>> 16;
  assign e_next    = e + 33'(iv);

  assign status.go         = !fresh && have_prev && (cur_min > prev_min);
  assign status.mod_done   = (cnt == 5'd1);
  assign status.modiv_done = (cnt == 5'd5);
  assign status.gap_ok     = ({26'd0, r_val} < dur);
  assign status.div_done   = (cnt == 5'(QW - 1));
  assign status.last       = out_item.last_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_min  <= '0;
      prev_lvl  <= '0;
    end else if (cmd.store) begin
      have_prev <= 1'b1;
      prev_min  <= cur_min;
      prev_lvl  <= cur_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_min <= in_item.event_minute + {{21{off[10]}}, off};
      prod_lg <= 33'(in_item.event_level) * 33'($signed({1'b0, gain}));
      fresh   <= in_item.new_series;
    end
    if (cmd.corr) begin
      cur_lvl <= sat16(40'(lvl_round));
      dur     <= cur_min - prev_min;
      cnt     <= '0;
    end
    if (cmd.mod_step) begin
      if (status.mod_done) begin
        msh <= {rem60_next, 26'd0};
        rm  <= '0;
        cnt <= '0;
      end else begin
        prod60 <= 64'(prev_min) * 64'(RECIP60);
        cnt    <= cnt + 5'd1;
      end
    end
    if (cmd.modiv_step) begin
      rm  <= rm_next;
      msh <= msh << 1;
      cnt <= cnt + 5'd1;
    end
    if (cmd.setup) begin
      e     <= 33'(r_val);
      k     <= '0;
      trunc <= (span < {1'b0, dur});
    end
    if (cmd.mul_e) begin
      ed <= EDW'(e[31:0]) * EDW'(COS_TABLE_DEPTH);
    end
    if (cmd.div_init) begin
      num <= {ed, 1'b0} + NW'(dur);
      dv  <= NW'({dur, 1'b0}) << (QW - 1);
      q   <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        num <= num - dv;
      end
      q   <= {q[QW-2:0], ge};
      dv  <= dv >> 1;
      cnt <= cnt + 5'd1;
    end
    if (cmd.look) begin
      w <= WTAB[qcap[IW-1:0]];
    end
    if (cmd.mul_w) begin
      pw <= 35'(change) * 35'($signed({1'b0, w}));
    end
    if (cmd.out_load) begin
      out_item.sample_minute <= prev_min + e[31:0];
      out_item.sample_level  <= sat16(40'(pw_round) + 40'(prev_lvl));
      out_item.last_sample   <= (e_next >= {1'b0, dur}) || (k == KW'(MAX_SAMPLES - 1));
      out_item.truncated     <= trunc;
    end
    if (cmd.advance) begin
      e <= e_next;
      k <= k + KW'(1);
    end
  end

endmodule

// ----- rtl/tci_checker.sv -----
// ----------------------------------------------------------------------------
// tci_checker
// Port-level checks of the tide interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module tci_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input tci_pkg::out_item_t         out_item,
  input logic                       pready
);

  a_reset_idle: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("Block is not idle after reset.");

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("Input taken while a word is still pending.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Block still ready after taking an extreme.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Stalled output word changed.");

  a_pready_high: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("Register port is not ready.");

endmodule

bind tide_cosine_interpolator tci_checker u_tci_checker (.*);

// ----- tb/tide_cosine_interpolator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tide_cosine_interpolator_tb
// Drives tide extremes through the interpolator and checks every sample word
// against a cycle-free predictor, across several register settings and
// several patterns of idling and stalling on both channels.
// ----------------------------------------------------------------------------
module tide_cosine_interpolator_tb;
  import tci_pkg::*;

  localparam int DEPTH = 256;
  localparam int MAXS  = 64;
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tide_cosine_interpolator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    in_item_t word;
    logic     fixed;
    int       n_samples;
  } stim_row_t;

  logic [16:0] blend_weight [DEPTH+1];
  logic [5:0]  cfg_interval;
  logic [10:0] cfg_high_off;
  logic [10:0] cfg_low_off;
  logic [15:0] cfg_high_gain;
  logic [15:0] cfg_low_gain;
  logic        prev_valid;
  logic [31:0] prev_minute;
  logic signed [15:0] prev_level;
  out_item_t   pending_samples [$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          predicted_count;
  logic        hold_off;
  logic        failed;
  longint      cycle_count = 0;

  function automatic logic signed [63:0] floor_div_pow2(input logic signed [63:0] p,
                                                         input int sh);
    return p >>> sh;
  endfunction

  function automatic logic signed [15:0] clip16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [63:0] taylor_cos(input logic [63:0] a);
    logic [63:0] dv [6];
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] t;
    dv = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
    a2 = (a * a) >> 30;
    term = 64'd1073741824;
    for (int k = 0; k < 6; k++) begin
      t = ((a2 * term) >> 30) / dv[k];
      if (t > 64'd1073741824) t = 64'd1073741824;
      term = 64'd1073741824 - t;
    end
    return term;
  endfunction

  task automatic build_weights();
    logic [63:0] one;
    logic [63:0] pi;
    logic [63:0] v;
    one = 64'd1073741824;
    pi = 64'd3373259426;
    for (int i = 0; i <= DEPTH; i++) begin
      if (2 * i <= DEPTH) v = one - taylor_cos(pi * i / DEPTH);
      else v = one + taylor_cos(pi * (DEPTH - i) / DEPTH);
      blend_weight[i] = 17'((v + 64'd16384) >> 15);
    end
  endtask

  // Returns the number of samples the extreme produces and queues them.
  function automatic int predict_samples(input in_item_t w);
    logic signed [63:0] off;
    logic [15:0] gain;
    logic [31:0] cur_min;
    logic signed [15:0] cur_lvl;
    logic [63:0] iv, dur, r, need, e, idx;
    logic signed [63:0] change, lv;
    logic trunc;
    out_item_t s;
    int n;
    n = 0;
    off = w.is_high ? 64'(signed'(cfg_high_off)) : 64'(signed'(cfg_low_off));
    gain = w.is_high ? cfg_high_gain : cfg_low_gain;
    cur_min = w.event_minute + off[31:0];
    cur_lvl = clip16(floor_div_pow2(64'(w.event_level) * $signed({48'd0, gain}) + 8192, 14));
    if (!w.new_series && prev_valid && cur_min > prev_minute) begin
      iv = (cfg_interval == 0) ? 64'd1 : 64'(cfg_interval);
      dur = 64'(cur_min) - 64'(prev_minute);
      r = iv - ((64'(prev_minute) % 60) % iv);
      if (r == iv) r = 0;
      need = 0;
      if (r < dur) need = (dur - r + iv - 1) / iv;
      trunc = need > MAXS;
      if (trunc) need = MAXS;
      change = 64'(cur_lvl) - 64'(prev_level);
      for (longint k = 0; k < need; k++) begin
        e = r + k * iv;
        idx = (2 * e * DEPTH + dur) / (2 * dur);
        if (idx > DEPTH) idx = DEPTH;
        lv = 64'(prev_level) +
             floor_div_pow2(change * $signed({47'd0, blend_weight[idx]}) + 32768, 16);
        s.sample_minute = prev_minute + e[31:0];
        s.sample_level = clip16(lv);
        s.last_sample = (k + 1 == need);
        s.truncated = trunc;
        pending_samples = {pending_samples, s};
        n++;
      end
    end
    prev_valid = 1'b1;
    prev_minute = cur_min;
    prev_level = cur_lvl;
    return n;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_INTERVAL:    cfg_interval = val[5:0];
      REG_HIGH_OFFSET: cfg_high_off = val[10:0];
      REG_LOW_OFFSET:  cfg_low_off = val[10:0];
      REG_HIGH_GAIN:   cfg_high_gain = val[15:0];
      REG_LOW_GAIN:    cfg_low_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (!in_ready);
    predicted_count = predict_samples(w);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_samples.size() != 0) @(posedge clk);
    in_valid <= 1'b0;
    repeat (1200) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] iv, input logic [10:0] ho,
                            input logic [10:0] lo, input logic [15:0] hg,
                            input logic [15:0] lg);
    write_reg(REG_INTERVAL, 32'(iv));
    write_reg(REG_HIGH_OFFSET, 32'(ho));
    write_reg(REG_LOW_OFFSET, 32'(lo));
    write_reg(REG_HIGH_GAIN, 32'(hg));
    write_reg(REG_LOW_GAIN, 32'(lg));
  endtask

  // Tide-like stream: alternating extremes, often about six hours apart.
  task automatic random_stream(input int count);
    in_item_t w;
    logic [31:0] t;
    logic hi;
    t = $urandom;
    hi = 1'($urandom_range(1));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        w.event_minute = $urandom;
        w.event_level = 16'($urandom);
        w.is_high = 1'($urandom_range(1));
        w.new_series = 1'($urandom_range(1));
      end else begin
        case ($urandom_range(3))
          0: t = t + $urandom_range(120);
          1: t = t + $urandom_range(1500);
          default: t = t + $urandom_range(300, 420);
        endcase
        hi = !hi;
        w.event_minute = t;
        w.event_level = hi ? 16'($urandom_range(1500)) : -16'($urandom_range(400));
        if ($urandom_range(7) == 0) w.event_level = 16'($urandom);
        w.is_high = hi;
        w.new_series = ($urandom_range(19) == 0);
      end
      send_word(w);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_item);
        failed = 1'b1;
      end else begin
        want = pending_samples.pop_front();
        if (out_item.sample_minute !== want.sample_minute ||
            out_item.sample_level !== want.sample_level ||
            out_item.last_sample !== want.last_sample ||
            out_item.truncated !== want.truncated) begin
          $display("%0t: expected %p actual %p", $time, want, out_item);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  stim_row_t table_rows [$];

  initial begin
    stim_row_t row;
    failed = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    predicted_count = 0;
    cfg_interval = 6'd10;
    cfg_high_off = '0;
    cfg_low_off = '0;
    cfg_high_gain = '0;
    cfg_low_gain = '0;
    prev_valid = 1'b0;
    prev_minute = '0;
    prev_level = '0;
    build_weights();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset the gains are zero: flat zero samples on the grid.
    table_rows = '{
      '{'{32'd0, 16'sd500, 1'b1, 1'b0}, 1'b1, 0},
      '{'{32'd25, 16'sd100, 1'b0, 1'b0}, 1'b1, 3},
      '{'{32'd20, 16'sd100, 1'b1, 1'b0}, 1'b1, 0},
      '{'{32'd20, 16'sd100, 1'b1, 1'b0}, 1'b1, 0},
      '{'{32'd21, 16'sd100, 1'b1, 1'b1}, 1'b1, 0}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_word(row.word);
      if (row.fixed && predicted_count != row.n_samples) begin
        $display("%0t: expected %0d samples actual %0d predicted", $time,
                 row.n_samples, predicted_count);
        failed = 1'b1;
      end
    end
    drain();

    set_config(6'd1, 11'd720, -11'sd720, 16'hFFFF, 16'h4000);
    table_rows = '{
      '{'{32'd1000, 16'sh7FFF, 1'b1, 1'b1}, 1'b0, 0},
      '{'{32'd1740, 16'sh8000, 1'b0, 1'b0}, 1'b0, 0},
      '{'{32'hFFFF_FF00, 16'sd300, 1'b0, 1'b1}, 1'b0, 0},
      '{'{32'hFFFF_FFF0, -16'sd300, 1'b1, 1'b0}, 1'b0, 0},
      '{'{32'd0, 16'sd0, 1'b1, 1'b0}, 1'b0, 0},
      '{'{32'd30, 16'sd1200, 1'b1, 1'b0}, 1'b0, 0},
      '{'{32'd50, -16'sd50, 1'b0, 1'b0}, 1'b0, 0}
    };
    foreach (table_rows[i]) send_word(table_rows[i].word);
    drain();

    set_config(6'd60, 11'd0, 11'd0, 16'h4000, 16'h4000);
    table_rows = '{
      '{'{32'd59, 16'sd100, 1'b1, 1'b1}, 1'b0, 0},
      '{'{32'd61, -16'sd100, 1'b0, 1'b0}, 1'b0, 0},
      '{'{32'd4000, 16'sd900, 1'b1, 1'b0}, 1'b0, 0},
      '{'{32'd4030, 16'sd900, 1'b1, 1'b0}, 1'b0, 0}
    };
    foreach (table_rows[i]) send_word(table_rows[i].word);
    drain();

    set_config(6'd0, 11'd5, -11'sd3, 16'h8000, 16'h2000);
    table_rows = '{
      '{'{32'd100, 16'sd10, 1'b1, 1'b1}, 1'b0, 0},
      '{'{32'd140, 16'sd20, 1'b0, 1'b0}, 1'b0, 0}
    };
    foreach (table_rows[i]) send_word(table_rows[i].word);
    drain();

    set_config(6'd10, 11'd37, -11'sd64, 16'h4000, 16'h3C00);
    random_stream(40);
    drain();

    send_idle_pct = 56;
    set_config(6'd15, -11'sd120, 11'd90, 16'h4400, 16'h4000);
    random_stream(30);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 56;
    set_config(6'd6, 11'd0, 11'd0, 16'h4000, 16'h4000);
    random_stream(30);
    drain();

    send_idle_pct = 28;
    recv_stall_pct = 28;
    set_config(6'd63, 11'd1, 11'd2, 16'hC000, 16'h1000);
    random_stream(30);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(6'd5, 11'd0, 11'd0, 16'h4000, 16'h4000);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_stream(30);
    join
    drain();

    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- tide_cosine_interpolator.f -----
rtl/tci_pkg.sv
rtl/tci_ctrl.sv
rtl/tci_datapath.sv
rtl/tide_cosine_interpolator.sv
rtl/tci_checker.sv
tb/tide_cosine_interpolator_tb.sv
